// File: hdl/tcce_pkg.sv
// tcce_pkg: shared types and constants for the text console character engine
// request operation codes, result action codes, parser phases and character codes
// no dependencies

package tcce_pkg;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_CURSOR = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_CURSOR = 3'd0,
      ACT_WRITE  = 3'd1,
      ACT_SCROLL = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_BEEP   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      PH_NORMAL = 3'b001,
      PH_ESCAPE = 3'b010,
      PH_DIGIT  = 3'b100
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [10:0] cell_index;
      logic [15:0] cell_value;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic        last;
   } rsp_type;

   localparam logic [7:0] CH_NUL       = 8'd0;
   localparam logic [7:0] CH_BELL      = 8'd7;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_LF        = 8'd10;
   localparam logic [7:0] CH_VT        = 8'd11;
   localparam logic [7:0] CH_FF        = 8'd12;
   localparam logic [7:0] CH_CR        = 8'd13;
   localparam logic [7:0] CH_ESC       = 8'd27;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_UPPER_B   = 8'h42;
   localparam logic [7:0] CH_UPPER_G   = 8'h47;
   localparam logic [7:0] CH_UPPER_N   = 8'h4e;
   localparam logic [7:0] CH_UPPER_R   = 8'h52;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_G   = 8'h67;
   localparam logic [7:0] CH_LOWER_N   = 8'h6e;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;

   localparam logic [3:0] CLR_DEFAULT      = 4'd7;
   localparam logic [3:0] CLR_RED          = 4'd4;
   localparam logic [3:0] CLR_BRIGHT_RED   = 4'd12;
   localparam logic [3:0] CLR_BLUE         = 4'd1;
   localparam logic [3:0] CLR_BRIGHT_BLUE  = 4'd9;
   localparam logic [3:0] CLR_GREEN        = 4'd2;
   localparam logic [3:0] CLR_BRIGHT_GREEN = 4'd10;

   // ten times the first digit byte plus the second, minus eleven times '0'
   localparam logic [11:0] DIGIT_BIAS = 12'(11 * 48);
   localparam logic [11:0] DIGIT_LOW  = 12'(11 * 48 + 1);
   localparam logic [11:0] DIGIT_HIGH = 12'(11 * 48 + 15);

   localparam logic [3:0] CELL_PAD = 4'd0;

endpackage

// File: hdl/tcce_step.sv
// tcce_step: next cursor, colour and parser state for one request, plus its results
// combinational; uses tcce_pkg

module tcce_step
   import tcce_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25,
   localparam int COL_W = $clog2(SCREEN_COLUMNS),
   localparam int ROW_W = $clog2(SCREEN_ROWS)
) (
   input  op_type           operation,
   input  logic [7:0]       char_code,
   input  logic [6:0]       new_column,
   input  logic [4:0]       new_row,
   input  logic [COL_W-1:0] col,
   input  logic [ROW_W-1:0] row,
   input  logic [3:0]       colour,
   input  phase_type        phase,
   input  logic [7:0]       digit,
   output logic [COL_W-1:0] col_next,
   output logic [ROW_W-1:0] row_next,
   output logic [3:0]       colour_next,
   output phase_type        phase_next,
   output logic [7:0]       digit_next,
   output rsp_type          first_rsp,
   output rsp_type          second_rsp,
   output logic             two_rsp
);

   localparam int CW1   = COL_W + 1;
   localparam int RW1   = ROW_W + 1;
   localparam int IDX_W = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);

   logic [CW1-1:0]   col_inc;
   logic [CW1-1:0]   tab_stop;
   logic [RW1-1:0]   row_inc;
   logic [11:0]      digit_sum;
   logic [11:0]      digit_val;
   logic [IDX_W-1:0] write_index;
   logic [15:0]      fill;
   logic             down;
   logic             wrote;
   logic             scroll;
   action_type       act;

   assign col_inc     = CW1'(col) + CW1'(1);
   assign tab_stop    = CW1'(col | COL_W'(7)) + CW1'(1);
   assign row_inc     = RW1'(row) + RW1'(1);
   assign digit_sum   = 12'(digit) * 12'd10 + 12'(char_code);
   assign digit_val   = digit_sum - DIGIT_BIAS;
   assign write_index = IDX_W'(row) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(col);
   assign fill        = {CELL_PAD, colour, CH_SPACE};

   always_comb begin
      col_next    = col;
      row_next    = row;
      colour_next = colour;
      phase_next  = phase;
      digit_next  = digit;
      act         = ACT_CURSOR;
      down        = 1'b0;
      wrote       = 1'b0;
      case (operation)
         OP_CURSOR: begin
            col_next = (new_column < SCREEN_COLUMNS) ? COL_W'(new_column)
                                                     : COL_W'(SCREEN_COLUMNS - 1);
            row_next = (new_row < SCREEN_ROWS) ? ROW_W'(new_row) : ROW_W'(SCREEN_ROWS - 1);
         end
         OP_CLEAR: begin
            act = ACT_CLEAR;
         end
         OP_PUT: begin
            if (char_code == CH_NUL) begin
               phase_next = PH_NORMAL;
            end else begin
               case (phase)
                  PH_ESCAPE: begin
                     phase_next = PH_NORMAL;
                     case (char_code)
                        CH_LOWER_N, CH_UPPER_N: colour_next = CLR_DEFAULT;
                        CH_LOWER_R: colour_next = CLR_RED;
                        CH_UPPER_R: colour_next = CLR_BRIGHT_RED;
                        CH_LOWER_B: colour_next = CLR_BLUE;
                        CH_UPPER_B: colour_next = CLR_BRIGHT_BLUE;
                        CH_LOWER_G: colour_next = CLR_GREEN;
                        CH_UPPER_G: colour_next = CLR_BRIGHT_GREEN;
                        default: begin
                           digit_next = char_code;
                           phase_next = PH_DIGIT;
                        end
                     endcase
                  end
                  PH_DIGIT: begin
                     phase_next = PH_NORMAL;
                     if (digit_sum >= DIGIT_LOW && digit_sum <= DIGIT_HIGH) begin
                        colour_next = digit_val[3:0];
                     end
                  end
                  default: begin
                     phase_next = PH_NORMAL;
                     case (char_code)
                        CH_ESC: phase_next = PH_ESCAPE;
                        CH_BELL: act = ACT_BEEP;
                        CH_LF, CH_VT, CH_FF: begin
                           col_next = '0;
                           down     = 1'b1;
                        end
                        CH_CR: col_next = '0;
                        CH_BACKSPACE: begin
                           if (col != '0) begin
                              col_next = col - COL_W'(1);
                           end
                        end
                        CH_TAB: begin
                           if (tab_stop >= SCREEN_COLUMNS) begin
                              col_next = '0;
                              down     = 1'b1;
                           end else begin
                              col_next = COL_W'(tab_stop);
                           end
                        end
                        default: begin
                           act   = ACT_WRITE;
                           wrote = 1'b1;
                           if (col_inc >= SCREEN_COLUMNS) begin
                              col_next = '0;
                              down     = 1'b1;
                           end else begin
                              col_next = COL_W'(col_inc);
                           end
                        end
                     endcase
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      scroll = 1'b0;
      if (down) begin
         if (row_inc >= SCREEN_ROWS) begin
            row_next = ROW_W'(SCREEN_ROWS - 1);
            scroll   = 1'b1;
         end else begin
            row_next = ROW_W'(row_inc);
         end
      end
   end

   always_comb begin
      first_rsp.action        = act;
      first_rsp.cell_index    = '0;
      first_rsp.cell_value    = '0;
      first_rsp.cursor_column = 7'(col_next);
      first_rsp.cursor_row    = 5'(row_next);
      first_rsp.last          = 1'b1;
      second_rsp              = first_rsp;
      second_rsp.action       = ACT_SCROLL;
      second_rsp.cell_value   = fill;
      two_rsp                 = 1'b0;
      if (wrote) begin
         first_rsp.cell_index = 11'(write_index);
         first_rsp.cell_value = {CELL_PAD, colour, char_code};
      end
      if (act == ACT_CLEAR) begin
         first_rsp.cell_value = fill;
      end
      if (scroll) begin
         if (wrote) begin
            first_rsp.last = 1'b0;
            two_rsp        = 1'b1;
         end else begin
            first_rsp = second_rsp;
         end
      end
   end

endmodule

// File: hdl/text_console_character_engine.sv
// text_console_character_engine: top level with request register, state and result registers
// uses tcce_pkg and tcce_step
// path: a request waits in the request reg, then its result is registered onto rsp_
// throughput: one request per cycle if not stalled; a scrolling write makes two results,
//   the scroll one leaves a pending reg while the next request waits in the request reg
// reset: cursor at column 0 row 0, colour 7, escape parser in normal text, all registers empty

module text_console_character_engine
   import tcce_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_new_column,
   input  logic [4:0]  req_new_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [10:0] rsp_cell_index,
   output logic [15:0] rsp_cell_value,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_last
);

   localparam int COL_W = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W = $clog2(SCREEN_ROWS);

   logic             req_full_ff;
   op_type           op_ff;
   logic [7:0]       char_ff;
   logic [6:0]       new_col_ff;
   logic [4:0]       new_row_ff;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [3:0]       colour_ff;
   phase_type        phase_ff;
   logic [7:0]       digit_ff;

   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;
   logic [3:0]       colour_in;
   phase_type        phase_in;
   logic [7:0]       digit_in;

   rsp_type          first_rsp;
   rsp_type          second_rsp;
   logic             two_rsp;

   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   rsp_type          pend_ff;
   logic             pend_valid_ff;

   logic             out_free;
   logic             send_pend;
   logic             process;
   logic             req_take;

   tcce_step #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS   (SCREEN_ROWS)
   ) u_step (
      .operation  (op_ff),
      .char_code  (char_ff),
      .new_column (new_col_ff),
      .new_row    (new_row_ff),
      .col        (col_ff),
      .row        (row_ff),
      .colour     (colour_ff),
      .phase      (phase_ff),
      .digit      (digit_ff),
      .col_next   (col_in),
      .row_next   (row_in),
      .colour_next(colour_in),
      .phase_next (phase_in),
      .digit_next (digit_in),
      .first_rsp  (first_rsp),
      .second_rsp (second_rsp),
      .two_rsp    (two_rsp)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign send_pend = pend_valid_ff && out_free;
   assign process   = req_full_ff && !pend_valid_ff && out_free;
   assign req_stall = req_full_ff && !process;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff   <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         colour_ff     <= CLR_DEFAULT;
         phase_ff      <= PH_NORMAL;
         digit_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            req_full_ff <= 1'b1;
         end else if (process) begin
            req_full_ff <= 1'b0;
         end
         if (process) begin
            col_ff        <= col_in;
            row_ff        <= row_in;
            colour_ff     <= colour_in;
            phase_ff      <= phase_in;
            digit_ff      <= digit_in;
            pend_valid_ff <= two_rsp;
         end else if (send_pend) begin
            pend_valid_ff <= 1'b0;
         end
         if (send_pend || process) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= op_type'(req_operation);
         char_ff    <= req_char_code;
         new_col_ff <= req_new_column;
         new_row_ff <= req_new_row;
      end
      if (process) begin
         pend_ff <= second_rsp;
      end
      if (send_pend) begin
         rsp_ff <= pend_ff;
      end else if (process) begin
         rsp_ff <= first_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_cell_index    = rsp_ff.cell_index;
   assign rsp_cell_value    = rsp_ff.cell_value;
   assign rsp_cursor_column = rsp_ff.cursor_column;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_last          = rsp_ff.last;

endmodule

// File: verif/text_console_character_engine_tb.sv
// text_console_character_engine_tb: self-checking testbench for the text console character engine
// predicts cursor, colour and escape parsing per request and checks every result in order
// depends on tcce_pkg and text_console_character_engine

module text_console_character_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcce_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int HOLD_CYCLES = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [7:0]  req_char_code;
   logic [6:0]  req_new_column;
   logic [4:0]  req_new_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_action;
   logic [10:0] rsp_cell_index;
   logic [15:0] rsp_cell_value;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic        rsp_last;

   int        error_count = 0;
   int        requests_sent = 0;
   bit        idle_on = 1'b1;
   bit        hold_request = 1'b0;
   rsp_type   pending_results[$];
   rsp_type   got, want;

   logic [6:0] scr_col;
   logic [4:0] scr_row;
   logic [3:0] scr_colour;
   phase_type  parse_phase;
   logic [7:0] held_digit;

   text_console_character_engine #(
      .SCREEN_COLUMNS(COLUMNS),
      .SCREEN_ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_char_code(req_char_code),
      .req_new_column(req_new_column),
      .req_new_row(req_new_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_action(rsp_action),
      .rsp_cell_index(rsp_cell_index),
      .rsp_cell_value(rsp_cell_value),
      .rsp_cursor_column(rsp_cursor_column),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] blank_cell();
      return {CELL_PAD, scr_colour, CH_SPACE};
   endfunction

   function automatic void push_result(action_type act, logic [10:0] idx, logic [15:0] val,
                                       logic fin);
      rsp_type r;
      r.action = act;
      r.cell_index = idx;
      r.cell_value = val;
      r.cursor_column = scr_col;
      r.cursor_row = scr_row;
      r.last = fin;
      pending_results.push_back(r);
   endfunction

   function automatic void predict_console(logic [1:0] op, logic [7:0] ch, logic [6:0] ncol,
                                           logic [4:0] nrow);
      int         col, row, colour_val;
      bit         wrote, scrolled;
      logic [10:0] widx;
      logic [15:0] wval;
      col = scr_col;
      row = scr_row;
      wrote = 1'b0;
      widx = '0;
      wval = '0;
      if (op == OP_CURSOR) begin
         scr_col = (ncol < COLUMNS) ? ncol : 7'(COLUMNS - 1);
         scr_row = (nrow < ROWS) ? nrow : 5'(ROWS - 1);
         push_result(ACT_CURSOR, '0, '0, 1'b1);
         return;
      end
      if (op == OP_CLEAR) begin
         push_result(ACT_CLEAR, '0, blank_cell(), 1'b1);
         return;
      end
      if (op == OP_NONE) begin
         push_result(ACT_CURSOR, '0, '0, 1'b1);
         return;
      end
      if (ch == CH_NUL) begin
         parse_phase = PH_NORMAL;
         push_result(ACT_CURSOR, '0, '0, 1'b1);
         return;
      end
      if (parse_phase == PH_ESCAPE) begin
         parse_phase = PH_NORMAL;
         case (ch)
            CH_LOWER_N, CH_UPPER_N: scr_colour = CLR_DEFAULT;
            CH_LOWER_R: scr_colour = CLR_RED;
            CH_UPPER_R: scr_colour = CLR_BRIGHT_RED;
            CH_LOWER_B: scr_colour = CLR_BLUE;
            CH_UPPER_B: scr_colour = CLR_BRIGHT_BLUE;
            CH_LOWER_G: scr_colour = CLR_GREEN;
            CH_UPPER_G: scr_colour = CLR_BRIGHT_GREEN;
            default: begin
               held_digit = ch;
               parse_phase = PH_DIGIT;
            end
         endcase
         push_result(ACT_CURSOR, '0, '0, 1'b1);
         return;
      end
      if (parse_phase == PH_DIGIT) begin
         colour_val = (int'(held_digit) - int'(CH_DIGIT_0)) * 10
                      + (int'(ch) - int'(CH_DIGIT_0));
         if (colour_val >= 1 && colour_val <= 15) scr_colour = colour_val[3:0];
         parse_phase = PH_NORMAL;
         push_result(ACT_CURSOR, '0, '0, 1'b1);
         return;
      end
      parse_phase = PH_NORMAL;
      case (ch)
         CH_ESC: parse_phase = PH_ESCAPE;
         CH_BELL: begin
            push_result(ACT_BEEP, '0, '0, 1'b1);
            return;
         end
         CH_LF, CH_VT, CH_FF: begin
            col = 0;
            row++;
         end
         CH_CR: col = 0;
         CH_BACKSPACE: if (col > 0) col--;
         CH_TAB: begin
            col = col + 8 - (col % 8);
            if (col >= COLUMNS) begin
               col = 0;
               row++;
            end
         end
         default: begin
            wrote = 1'b1;
            widx = 11'(row * COLUMNS + col);
            wval = {CELL_PAD, scr_colour, ch};
            col++;
            if (col >= COLUMNS) begin
               col = 0;
               row++;
            end
         end
      endcase
      scrolled = (row >= ROWS);
      if (scrolled) row = ROWS - 1;
      scr_col = 7'(col);
      scr_row = 5'(row);
      if (wrote) push_result(ACT_WRITE, widx, wval, !scrolled);
      if (scrolled) push_result(ACT_SCROLL, '0, blank_cell(), 1'b1);
      else if (!wrote) push_result(ACT_CURSOR, '0, '0, 1'b1);
   endfunction

   function automatic void report_mismatch(string field, int exp_v, int act_v);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      error_count++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_action, rsp_cell_index, rsp_cell_value, rsp_cursor_column, rsp_cursor_row,
                rsp_last};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.action !== want.action)
               report_mismatch("action", want.action, got.action);
            if (got.cell_index !== want.cell_index)
               report_mismatch("cell_index", want.cell_index, got.cell_index);
            if (got.cell_value !== want.cell_value)
               report_mismatch("cell_value", want.cell_value, got.cell_value);
            if (got.cursor_column !== want.cursor_column)
               report_mismatch("cursor_column", want.cursor_column, got.cursor_column);
            if (got.cursor_row !== want.cursor_row)
               report_mismatch("cursor_row", want.cursor_row, got.cursor_row);
            if (got.last !== want.last)
               report_mismatch("last", want.last, got.last);
         end
      end
   end

   initial begin : receiver
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                               input logic [6:0] ncol, input logic [4:0] nrow);
      req_valid <= 1'b1;
      req_operation <= op;
      req_char_code <= ch;
      req_new_column <= ncol;
      req_new_row <= nrow;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_console(op, ch, ncol, nrow);
      requests_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_put(input logic [7:0] ch);
      send_request(OP_PUT, ch, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [7:0] control_code(int sel);
      case (sel)
         0: return CH_BELL;
         1: return CH_BACKSPACE;
         2: return CH_TAB;
         3: return CH_LF;
         4: return CH_VT;
         5: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] colour_letter(int sel);
      case (sel)
         0: return CH_LOWER_N;
         1: return CH_UPPER_N;
         2: return CH_LOWER_R;
         3: return CH_UPPER_R;
         4: return CH_LOWER_B;
         5: return CH_UPPER_B;
         6: return CH_LOWER_G;
         default: return CH_UPPER_G;
      endcase
   endfunction

   task automatic test_cursor_and_clear();
      send_request(OP_CURSOR, 8'hff, 7'd127, 5'd31);
      send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0);
      send_request(OP_NONE, 8'hff, 7'd127, 5'd31);
      send_request(OP_CURSOR, 8'h00, 7'd0, 5'd0);
      wait_for_results();
   endtask

   task automatic test_control_codes();
      send_put(CH_BELL);
      send_put(CH_BACKSPACE);
      send_put(8'h41);
      send_put(CH_BACKSPACE);
      send_put(CH_TAB);
      send_put(CH_CR);
      send_put(CH_LF);
      send_put(CH_NUL);
      wait_for_results();
   endtask

   task automatic test_colour_escapes();
      send_put(CH_ESC);
      send_put(CH_UPPER_R);
      send_put(CH_ESC);
      send_put(CH_DIGIT_0 + 8'd1);
      send_put(CH_DIGIT_0 + 8'd4);
      send_put(CH_ESC);
      send_put(CH_DIGIT_0 + 8'd9);
      send_put(CH_DIGIT_0 + 8'd9);
      send_put(CH_ESC);
      send_put(CH_NUL);
      send_put(8'h78);
      wait_for_results();
   endtask

   task automatic test_scroll_at_bottom();
      send_request(OP_CURSOR, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
      send_put(8'hff);
      send_request(OP_CURSOR, 8'h00, 7'd75, 5'(ROWS - 1));
      send_put(CH_TAB);
      send_put(CH_LF);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count);
      int first_sent, n;
      logic [7:0] digit;
      first_sent = requests_sent;
      while (requests_sent - first_sent < count) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3: send_put(8'($urandom_range(32, 255)));
            4, 5: send_put(control_code($urandom_range(0, 6)));
            6: begin
               send_put(CH_ESC);
               send_put(colour_letter($urandom_range(0, 7)));
            end
            7: begin
               send_put(CH_ESC);
               digit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : CH_DIGIT_0 + 8'($urandom_range(0, 2));
               send_put(digit);
               digit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : CH_DIGIT_0 + 8'($urandom_range(0, 9));
               send_put(digit);
            end
            8: send_request(OP_CURSOR, 8'($urandom_range(0, 255)),
                  ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(70, 79)),
                  ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(20, 24)));
            9: send_request(2'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
            10: send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
            default: begin
               n = $urandom_range(5, 20);
               repeat (n) send_put(8'($urandom_range(32, 255)));
            end
         endcase
      end
      wait_for_results();
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_request = 1'b1;
      send_request(OP_CURSOR, 8'h00, 7'd70, 5'(ROWS - 1));
      repeat (40) send_put(8'($urandom_range(32, 255)));
      wait_for_results();
      idle_on = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_PUT;
      req_char_code <= '0;
      req_new_column <= '0;
      req_new_row <= '0;
      scr_col = '0;
      scr_row = '0;
      scr_colour = CLR_DEFAULT;
      parse_phase = PH_NORMAL;
      held_digit = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_cursor_and_clear();
      test_control_codes();
      test_colour_escapes();
      test_scroll_at_bottom();
      test_random_traffic(220);
      test_backpressure();
      test_random_traffic(200);
      idle_on = 1'b0;
      test_random_traffic(60);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
hdl/tcce_pkg.sv
hdl/tcce_step.sv
hdl/text_console_character_engine.sv
verif/text_console_character_engine_tb.sv
